@@ rtl/trw_pkg.sv @@
package trw_pkg;

    // default window state width
    localparam int WINDOW_BITS_DEFAULT = 16;
    // adder width that goes with the default window width
    localparam int ALU_WIDTH_DEFAULT = 18;

    // register indexes on the write port
    localparam logic [1:0] CFG_WINDOW_CLAMP      = 2'd0;
    localparam logic [1:0] CFG_INITIAL_WINDOW    = 2'd1;
    localparam logic [1:0] CFG_INITIAL_THRESHOLD = 2'd2;

    // register reset values
    localparam logic [15:0] CLAMP_RESET          = 16'hFFFF;
    localparam logic [15:0] INIT_WINDOW_RESET    = 16'd10;
    localparam logic [15:0] INIT_THRESHOLD_RESET = 16'hFFFF;

    // item opcodes
    localparam logic [1:0] OP_ACK  = 2'd0;
    localparam logic [1:0] OP_LOSS = 2'd1;
    localparam logic [1:0] OP_SET  = 2'd2;
    localparam logic [1:0] OP_NOP  = 2'd3;

    localparam logic [15:0] MIN_THRESHOLD = 16'd2;

    typedef struct packed {
        logic [1:0]  op;
        logic [15:0] acked_count;
        logic        window_limited;
        logic [15:0] new_window;
    } trw_in_t;

    typedef struct packed {
        logic [15:0] window;
        logic [15:0] threshold;
        logic        in_slow_start;
    } trw_out_t;

    // adder control: subtract is invert_b with carry_in set
    typedef struct packed {
        logic invert_b;
        logic carry_in;
    } trw_alu_ctl_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SS_CHECK,
        ST_SS_ADD,
        ST_SS_LIMIT,
        ST_SS_CLAMP,
        ST_AI_WRAP,
        ST_AI_ADD,
        ST_AI_CHECK,
        ST_DIV,
        ST_AI_GROW,
        ST_AI_CLAMP,
        ST_LOSS,
        ST_SET,
        ST_PUBLISH
    } trw_state_t;

endpackage

@@ rtl/trw_alu.sv @@
module trw_alu import trw_pkg::*; #(
    parameter int WIDTH = ALU_WIDTH_DEFAULT
) (
    input  logic [WIDTH-1:0] a,
    input  logic [WIDTH-1:0] b,
    input  trw_alu_ctl_t     ctl,
    output logic [WIDTH-1:0] sum,
    output logic             carry_out
);

    logic [WIDTH-1:0] b_op;

    assign b_op = ctl.invert_b ? ~b : b;

    // on subtract, carry_out set means a >= b
    assign {carry_out, sum} = {1'b0, a} + {1'b0, b_op} + (WIDTH + 1)'(ctl.carry_in);

endmodule

@@ rtl/tcp_reno_window_update.sv @@
// TCP Reno congestion window update. Holds the congestion window, the
// additive-increase ack counter and the slow-start threshold; every accepted
// item returns exactly one result with the window, the threshold and a slow
// start flag taken after the item. Op ack with window_limited set runs slow
// start if the window is at most the threshold (growth up to threshold and
// window_clamp) and then, for any acked count that slow start leaves, additive
// increase: the counter absorbs acks and each full window's worth adds one
// segment, through a restoring divide by the window. Op loss sets threshold
// to half the window, at least 2; op set loads the window and clears the
// counter; op code 3 and a non-limited ack only report. Apart from the divide
// step count, all arithmetic goes through one shared add/subtract unit under
// a sequencer; the divide takes max(WINDOW_BITS,16) + 1 steps, and an item
// waits to publish while the output register still holds an older result.
// s_ready is high only while the sequencer is idle. A finished result waits
// in the output register, and the next item is accepted meanwhile. Register
// writes: index 0 sets window_clamp at once; initial_window and
// initial_threshold come back to their reset values (10 and 65535) at every
// reset, which is when they are applied, so writes to them leave no trace.
module tcp_reno_window_update import trw_pkg::*; #(
    parameter int WINDOW_BITS = WINDOW_BITS_DEFAULT
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  trw_in_t     s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output trw_out_t    m_data
);

    localparam int W    = WINDOW_BITS;
    localparam int DW   = (WINDOW_BITS > 16) ? WINDOW_BITS : 16;
    localparam int QW   = DW + 1;        // ack counter sum / dividend
    localparam int SW   = DW + 2;        // shared adder width
    localparam int CNTW = $clog2(QW);

    // architectural state
    trw_state_t      state_reg, state_next;
    logic [W-1:0]    cw_reg, cw_next;
    logic [W-1:0]    thr_reg, thr_next;
    logic [W-1:0]    acc_reg, acc_next;     // also the divide remainder
    logic [15:0]     clamp_reg, clamp_next;

    // work registers
    logic [15:0]     opnd_reg, opnd_next;   // acked count, or new window
    logic [SW-1:0]   t_reg, t_next;
    logic [W-1:0]    w_reg, w_next;         // divisor
    logic [QW-1:0]   q_reg, q_next;         // dividend in, quotient out
    logic            inc_reg, inc_next;
    logic [CNTW-1:0] cnt_reg, cnt_next;

    trw_out_t        out_reg, out_next;
    logic            m_valid_reg, m_valid_next;

    // shared unit
    logic [SW-1:0]   alu_a, alu_b, alu_sum;
    trw_alu_ctl_t    alu_ctl;
    logic            alu_carry;

    logic [W-1:0]    win_div;
    logic [SW-1:0]   div_shift;

    localparam trw_alu_ctl_t ALU_ADD = '{invert_b: 1'b0, carry_in: 1'b0};
    localparam trw_alu_ctl_t ALU_SUB = '{invert_b: 1'b1, carry_in: 1'b1};

    trw_alu #(
        .WIDTH(SW)
    ) u_alu (
        .a         (alu_a),
        .b         (alu_b),
        .ctl       (alu_ctl),
        .sum       (alu_sum),
        .carry_out (alu_carry)
    );

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

    // zero window divides as one
    assign win_div   = (cw_reg == '0) ? W'(1) : cw_reg;
    assign div_shift = SW'({acc_reg, q_reg[QW-1]});

    always_comb begin
        clamp_next = clamp_reg;
        if (cfg_we) begin
            unique case (cfg_index) inside
                CFG_WINDOW_CLAMP: clamp_next = cfg_data;
                CFG_INITIAL_WINDOW, CFG_INITIAL_THRESHOLD: ;  // applied at reset
                default: ;
            endcase
        end
    end

    always_comb begin
        state_next   = state_reg;
        cw_next      = cw_reg;
        thr_next     = thr_reg;
        acc_next     = acc_reg;
        opnd_next    = opnd_reg;
        t_next       = t_reg;
        w_next       = w_reg;
        q_next       = q_reg;
        inc_next     = inc_reg;
        cnt_next     = cnt_reg;
        out_next     = out_reg;
        m_valid_next = m_valid_reg && !m_ready;
        alu_a        = '0;
        alu_b        = '0;
        alu_ctl      = ALU_ADD;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    if (s_data.op == OP_SET) begin
                        opnd_next  = s_data.new_window;
                        state_next = ST_SET;
                    end else begin
                        opnd_next = s_data.acked_count;
                        if (s_data.op == OP_LOSS) begin
                            state_next = ST_LOSS;
                        end else if (s_data.op == OP_ACK && s_data.window_limited) begin
                            state_next = ST_SS_CHECK;
                        end else begin
                            state_next = ST_PUBLISH;
                        end
                    end
                end
            end

            // window <= threshold?
            ST_SS_CHECK: begin
                alu_a      = SW'(thr_reg);
                alu_b      = SW'(cw_reg);
                alu_ctl    = ALU_SUB;
                state_next = alu_carry ? ST_SS_ADD : ST_AI_WRAP;
            end

            ST_SS_ADD: begin
                alu_a      = SW'(cw_reg);
                alu_b      = SW'(opnd_reg);
                t_next     = alu_sum;
                state_next = ST_SS_LIMIT;
            end

            // limit to threshold; the overshoot is the leftover ack count
            ST_SS_LIMIT: begin
                alu_a   = t_reg;
                alu_b   = SW'(thr_reg);
                alu_ctl = ALU_SUB;
                if (alu_carry) begin
                    opnd_next = 16'(alu_sum);
                    t_next    = SW'(thr_reg);
                end else begin
                    opnd_next = '0;
                end
                state_next = ST_SS_CLAMP;
            end

            ST_SS_CLAMP: begin
                alu_a      = t_reg;
                alu_b      = SW'(clamp_reg);
                alu_ctl    = ALU_SUB;
                cw_next    = alu_carry ? W'(clamp_reg) : W'(t_reg);
                state_next = (opnd_reg == '0) ? ST_PUBLISH : ST_AI_WRAP;
            end

            // a full counter from earlier wraps first
            ST_AI_WRAP: begin
                alu_a   = SW'(acc_reg);
                alu_b   = SW'(win_div);
                alu_ctl = ALU_SUB;
                w_next  = win_div;
                inc_next = alu_carry;
                if (alu_carry) begin
                    acc_next = '0;
                end
                state_next = ST_AI_ADD;
            end

            ST_AI_ADD: begin
                alu_a      = SW'(acc_reg);
                alu_b      = SW'(opnd_reg);
                q_next     = QW'(alu_sum);
                state_next = ST_AI_CHECK;
            end

            ST_AI_CHECK: begin
                alu_a   = SW'(q_reg);
                alu_b   = SW'(w_reg);
                alu_ctl = ALU_SUB;
                if (alu_carry) begin
                    acc_next   = '0;
                    cnt_next   = CNTW'(QW - 1);
                    state_next = ST_DIV;
                end else begin
                    acc_next   = W'(q_reg);
                    q_next     = '0;
                    state_next = ST_AI_GROW;
                end
            end

            // restoring divide, one quotient bit a cycle
            ST_DIV: begin
                alu_a   = div_shift;
                alu_b   = SW'(w_reg);
                alu_ctl = ALU_SUB;
                if (alu_carry) begin
                    acc_next = W'(alu_sum);
                    q_next   = {q_reg[QW-2:0], 1'b1};
                end else begin
                    acc_next = W'(div_shift);
                    q_next   = {q_reg[QW-2:0], 1'b0};
                end
                if (cnt_reg == '0) begin
                    state_next = ST_AI_GROW;
                end else begin
                    cnt_next = cnt_reg - CNTW'(1);
                end
            end

            ST_AI_GROW: begin
                alu_a      = SW'(cw_reg);
                alu_b      = SW'(q_reg);
                alu_ctl    = '{invert_b: 1'b0, carry_in: inc_reg};
                t_next     = alu_sum;
                state_next = ST_AI_CLAMP;
            end

            ST_AI_CLAMP: begin
                alu_a      = t_reg;
                alu_b      = SW'(clamp_reg);
                alu_ctl    = ALU_SUB;
                cw_next    = alu_carry ? W'(clamp_reg) : W'(t_reg);
                state_next = ST_PUBLISH;
            end

            ST_LOSS: begin
                alu_a      = SW'(cw_reg >> 1);
                alu_b      = SW'(MIN_THRESHOLD);
                alu_ctl    = ALU_SUB;
                thr_next   = alu_carry ? W'(cw_reg >> 1) : W'(MIN_THRESHOLD);
                state_next = ST_PUBLISH;
            end

            ST_SET: begin
                cw_next    = W'(opnd_reg);
                acc_next   = '0;
                state_next = ST_PUBLISH;
            end

            // waits here while an older result is still held
            ST_PUBLISH: begin
                alu_a   = SW'(thr_reg);
                alu_b   = SW'(cw_reg);
                alu_ctl = ALU_SUB;
                if (!m_valid_reg || m_ready) begin
                    out_next.window        = 16'(cw_reg);
                    out_next.threshold     = 16'(thr_reg);
                    out_next.in_slow_start = alu_carry;
                    m_valid_next           = 1'b1;
                    state_next             = ST_IDLE;
                end
            end

            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            cw_reg      <= W'(INIT_WINDOW_RESET);
            thr_reg     <= W'(INIT_THRESHOLD_RESET);
            acc_reg     <= '0;
            clamp_reg   <= CLAMP_RESET;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            cw_reg      <= cw_next;
            thr_reg     <= thr_next;
            acc_reg     <= acc_next;
            clamp_reg   <= clamp_next;
        end
    end

    always_ff @(posedge aclk) begin
        opnd_reg <= opnd_next;
        t_reg    <= t_next;
        w_reg    <= w_next;
        q_reg    <= q_next;
        inc_reg  <= inc_next;
        cnt_reg  <= cnt_next;
        out_reg  <= out_next;
    end

endmodule

@@ rtl/trw_checker.sv @@
module trw_checker import trw_pkg::*; (
    input logic     aclk,
    input logic     aresetn,
    input logic     s_valid,
    input logic     s_ready,
    input trw_in_t  s_data,
    input logic     m_valid,
    input logic     m_ready,
    input trw_out_t m_data
);

    // one item at a time in the sequencer
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input taken while an item is in work");

    a_result_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_data)))
        else $error("held result dropped or changed");

    a_slow_start_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.in_slow_start == (m_data.window <= m_data.threshold)))
        else $error("slow start flag disagrees with window and threshold");

    a_threshold_floor: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.threshold >= MIN_THRESHOLD))
        else $error("threshold below floor");

endmodule

bind tcp_reno_window_update trw_checker u_trw_checker (.*);

@@ dv/trw_window_checker.sv @@
module trw_window_checker import trw_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        s_valid,
    input  logic        s_ready,
    input  trw_in_t     s_data,
    input  logic        m_valid,
    input  logic        m_ready,
    input  trw_out_t    m_data,
    output int          mismatches,
    output int          outstanding,
    output int          results_checked
);

    logic [15:0] clamp;
    logic [15:0] cwnd;
    logic [15:0] acc;
    logic [15:0] ssthresh;
    trw_out_t    expected_windows[$];

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        mismatches++;
        if (mismatches <= 40) begin
            $display("[%0t] mismatch on %s: got %0d, want %0d", $time, what, got, want);
        end
    endtask

    // Applies one item to the local window state and returns the window report.
    task automatic advance_window(input trw_in_t item, output trw_out_t res);
        logic [31:0] w;
        logic [31:0] c;
        logic [31:0] left;
        logic [31:0] divisor;
        logic [31:0] sum;
        logic [31:0] steps;
        logic        ss_done;
        case (item.op)
            OP_ACK: begin
                if (item.window_limited) begin
                    w       = 32'(cwnd);
                    left    = 32'(item.acked_count);
                    ss_done = 1'b0;
                    if (w <= 32'(ssthresh)) begin
                        c       = (w + left < 32'(ssthresh)) ? w + left : 32'(ssthresh);
                        left    = left - (c - w);
                        w       = (c < 32'(clamp)) ? c : 32'(clamp);
                        ss_done = (left == 0);
                    end
                    if (!ss_done) begin
                        // divisor is the window after slow start; zero counts as one
                        divisor = (w == 0) ? 32'd1 : w;
                        sum     = 32'(acc);
                        if (sum >= divisor) begin
                            sum = 0;
                            w   = w + 1;
                        end
                        sum = sum + left;
                        if (sum >= divisor) begin
                            steps = sum / divisor;
                            sum   = sum - steps * divisor;
                            w     = w + steps;
                        end
                        if (w > 32'(clamp)) begin
                            w = 32'(clamp);
                        end
                        acc = sum[15:0];
                    end
                    cwnd = w[15:0];
                end
            end
            OP_LOSS: begin
                ssthresh = ({1'b0, cwnd[15:1]} < MIN_THRESHOLD) ? MIN_THRESHOLD
                                                                : {1'b0, cwnd[15:1]};
            end
            OP_SET: begin
                cwnd = item.new_window;
                acc  = '0;
            end
            default: begin
            end
        endcase
        res.window        = cwnd;
        res.threshold     = ssthresh;
        res.in_slow_start = (cwnd <= ssthresh);
    endtask

    always @(posedge aclk) begin
        trw_out_t want;
        if (!aresetn) begin
            clamp    = CLAMP_RESET;
            cwnd     = INIT_WINDOW_RESET;
            acc      = '0;
            ssthresh = INIT_THRESHOLD_RESET;
            expected_windows.delete();
        end else begin
            // initial window and threshold only load at reset
            if (cfg_we && cfg_index == CFG_WINDOW_CLAMP) begin
                clamp = cfg_data;
            end
            if (s_valid && s_ready) begin
                advance_window(s_data, want);
                expected_windows.push_back(want);
            end
            if (m_valid && m_ready) begin
                if (expected_windows.size() == 0) begin
                    report_mismatch("result with none pending", m_data.window, 0);
                end else begin
                    want = expected_windows.pop_front();
                    results_checked++;
                    if (m_data.window !== want.window) begin
                        report_mismatch("window", m_data.window, want.window);
                    end
                    if (m_data.threshold !== want.threshold) begin
                        report_mismatch("threshold", m_data.threshold, want.threshold);
                    end
                    if (m_data.in_slow_start !== want.in_slow_start) begin
                        report_mismatch("in_slow_start", m_data.in_slow_start,
                                        want.in_slow_start);
                    end
                end
            end
        end
        outstanding <= expected_windows.size();
    end

endmodule

@@ dv/tb_tcp_reno_window_update.sv @@
module tb_tcp_reno_window_update;
    import trw_pkg::*;

    // Slowest item is additive increase with a full divide.
    localparam int DRAIN_CYCLES = 40;
    localparam int unsigned CYCLE_LIMIT = 1000000;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = CFG_WINDOW_CLAMP;
    logic [15:0] cfg_data = '0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    trw_in_t     s_data = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    trw_out_t    m_data;

    int          mismatches;
    int          outstanding;
    int          results_checked;

    // idle percentages for each side; changed between phases
    int          sender_idle_pct = 11;
    int          receiver_idle_pct = 86;
    int          op_counts[4] = '{0, 0, 0, 0};
    int unsigned cycle_count = 0;

    tcp_reno_window_update u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    trw_window_checker u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_data          (s_data),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_data          (m_data),
        .mismatches      (mismatches),
        .outstanding     (outstanding),
        .results_checked (results_checked)
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    // Watchdog: a hung handshake ends the run here.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Receiver back-pressure, redrawn every cycle.
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= receiver_idle_pct);
    end

    function automatic trw_in_t make_item(input logic [1:0] op, input logic [15:0] acked,
                                          input logic limited, input logic [15:0] nw);
        trw_in_t item;
        item.op             = op;
        item.acked_count    = acked;
        item.window_limited = limited;
        item.new_window     = nw;
        return item;
    endfunction

    // Mostly limited acks with small counts so additive increase gets a workout;
    // losses and sets often enough to keep the window moving around the threshold.
    // Fields an op ignores still carry random bits.
    function automatic trw_in_t random_item();
        trw_in_t     item;
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 62) begin
            item.op = OP_ACK;
        end else if (pick < 74) begin
            item.op = OP_LOSS;
        end else if (pick < 88) begin
            item.op = OP_SET;
        end else begin
            item.op = OP_NOP;
        end
        item.window_limited = ($urandom_range(99) < 85);
        case ($urandom_range(9))
            0, 1, 2, 3, 4: item.acked_count = 16'($urandom_range(0, 6));
            5, 6:          item.acked_count = 16'($urandom_range(7, 400));
            7:             item.acked_count = 16'($urandom_range(0, 65535));
            8:             item.acked_count = '0;
            default:       item.acked_count = '1;
        endcase
        case ($urandom_range(9))
            0, 1, 2, 3: item.new_window = 16'($urandom_range(1, 40));
            4, 5:       item.new_window = 16'($urandom_range(41, 3000));
            6, 7:       item.new_window = 16'($urandom_range(0, 65535));
            8:          item.new_window = 16'($urandom_range(0, 1));
            default:    item.new_window = '1;
        endcase
        return item;
    endfunction

    // Presents one item and returns at the edge where it is accepted. Valid is
    // only dropped when a gap is taken, so back-to-back items keep it high.
    task automatic push_item(input trw_in_t item);
        if ($urandom_range(99) < sender_idle_pct) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= item;
        op_counts[item.op]++;
        do begin
            @(posedge aclk);
        end while (!s_ready);
    endtask

    // Sender holds off until every predicted window report has come back.
    task automatic wait_for_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) begin
            @(posedge aclk);
        end
    endtask

    task automatic write_reg(input logic [1:0] index, input logic [15:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(posedge aclk);
        cfg_we <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic run_random(input int count);
        for (int i = 0; i < count; i++) begin
            push_item(random_item());
        end
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Initial window/threshold writes only matter at a reset, and reset
        // is never asserted again, so the state keeps its reset values.
        write_reg(CFG_WINDOW_CLAMP, 16'hFFFF);
        write_reg(CFG_INITIAL_WINDOW, 16'd1);
        write_reg(CFG_INITIAL_THRESHOLD, 16'd2);

        // Directed walk from the reset state (window 10, threshold max).
        push_item(make_item(OP_ACK, 16'd0, 1'b1, 16'd1));       // slow start, nothing acked
        push_item(make_item(OP_ACK, 16'hFFFF, 1'b0, 16'hFFFF)); // not limited: no change
        push_item(make_item(OP_ACK, 16'd5, 1'b1, 16'd0));       // slow start to 15
        push_item(make_item(OP_NOP, 16'hFFFF, 1'b1, 16'hFFFF)); // unused op only reports
        push_item(make_item(OP_LOSS, 16'd0, 1'b0, 16'd0));      // threshold to 7
        push_item(make_item(OP_ACK, 16'd14, 1'b1, 16'd0));      // counter just short
        push_item(make_item(OP_ACK, 16'd1, 1'b1, 16'd0));       // one full window
        push_item(make_item(OP_ACK, 16'hFFFF, 1'b1, 16'd0));    // long divide
        push_item(make_item(OP_SET, 16'd0, 1'b0, 16'd0));       // window loaded as zero
        push_item(make_item(OP_LOSS, 16'd0, 1'b0, 16'd0));      // half of zero -> floor of 2
        push_item(make_item(OP_ACK, 16'd1, 1'b1, 16'd0));
        push_item(make_item(OP_LOSS, 16'd0, 1'b0, 16'd0));      // half of one -> floor
        push_item(make_item(OP_ACK, 16'd3, 1'b1, 16'd0));       // slow start then leftover
        push_item(make_item(OP_SET, 16'd0, 1'b0, 16'hFFFF));
        push_item(make_item(OP_LOSS, 16'd0, 1'b0, 16'd0));      // threshold 32767
        push_item(make_item(OP_ACK, 16'hFFFF, 1'b1, 16'd0));    // growth past max, clamped
        push_item(make_item(OP_ACK, 16'hFFFF, 1'b1, 16'd0));
        push_item(make_item(OP_SET, 16'd0, 1'b0, 16'd1));
        push_item(make_item(OP_ACK, 16'hFFFF, 1'b1, 16'd0));    // ss hits threshold, rest AI
        push_item(make_item(OP_ACK, 16'd0, 1'b0, 16'h5555));
        push_item(make_item(OP_SET, 16'd0, 1'b0, 16'hAAAA));
        run_random(600);

        // Tightest clamp; a window loaded above it must be pulled down.
        wait_for_results();
        write_reg(CFG_WINDOW_CLAMP, 16'd1);
        write_reg(CFG_INITIAL_WINDOW, 16'hFFFF);
        write_reg(CFG_INITIAL_THRESHOLD, 16'hFFFF);
        push_item(make_item(OP_SET, 16'd0, 1'b0, 16'd5000));
        push_item(make_item(OP_ACK, 16'd1, 1'b1, 16'd0));
        run_random(150);

        // Swap the idle pattern: sender mostly idle, receiver mostly ready.
        wait_for_results();
        sender_idle_pct   = 86;
        receiver_idle_pct = 11;
        write_reg(CFG_WINDOW_CLAMP, 16'd200);
        run_random(550);

        // A zero clamp keeps the window at zero going into additive increase,
        // the only way to reach the divide-by-one fallback.
        wait_for_results();
        write_reg(CFG_WINDOW_CLAMP, 16'd0);
        push_item(make_item(OP_SET, 16'd0, 1'b0, 16'd0));
        push_item(make_item(OP_LOSS, 16'd0, 1'b0, 16'd0));
        push_item(make_item(OP_ACK, 16'd5, 1'b1, 16'd0));
        push_item(make_item(OP_ACK, 16'hFFFF, 1'b1, 16'd0));

        // Full clamp, no idling on either side.
        wait_for_results();
        sender_idle_pct   = 0;
        receiver_idle_pct = 0;
        write_reg(CFG_WINDOW_CLAMP, 16'hFFFF);
        run_random(450);

        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Ran %0d ack, %0d loss, %0d set and %0d unused-op items over clamps",
                 op_counts[OP_ACK], op_counts[OP_LOSS], op_counts[OP_SET], op_counts[OP_NOP]);
        $display("65535, 1, 200, 0; %0d window reports compared, %0d mismatches",
                 results_checked, mismatches);
        if (mismatches == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
